@@ rtl/core/wavelength_spectrum_binning_unit_defines.svh @@
// assertion macros for the wavelength spectrum binning unit checker
`ifndef WAVELENGTH_SPECTRUM_BINNING_UNIT_DEFINES_SVH
`define WAVELENGTH_SPECTRUM_BINNING_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define WSB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsb port check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define WSB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsb port check failed");

`endif

@@ rtl/core/wsb_pkg.sv @@
// shared constants, codes and control structs of the spectrum binning unit
`timescale 1ns / 1ps
`default_nettype none

package wsb_pkg;

	// bin store geometry
	localparam int MAX_BINS = 1024;
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int NBINS_W  = $clog2(MAX_BINS + 1);

	// field widths
	localparam int IDX_W      = 10;
	localparam int NU_W       = 48;
	localparam int ENERGY_W   = 32;
	localparam int ACC_W      = 48;
	localparam int LAM_W      = 28;
	localparam int BINS_CFG_W = 11;
	localparam int FLUX_W     = 32;
	localparam int PROD_W     = ENERGY_W + FLUX_W;
	localparam int PROD2_W    = LAM_W + NBINS_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// shared divider
	localparam int DIV_N_W   = 56;
	localparam int DIV_D_W   = 48;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	// c * 1e8 A/cm * 16 / 1000 Hz/kHz
	localparam logic [DIV_N_W-1:0] WAVE_NUM = 56'd47966793280000000;

	// register reset values
	localparam logic [LAM_W-1:0]      LAMBDA_MIN_RST = 28'd8000;
	localparam logic [LAM_W-1:0]      LAMBDA_MAX_RST = 28'd320000;
	localparam logic [BINS_CFG_W-1:0] BINS_RST       = 11'd1024;
	localparam logic [FLUX_W-1:0]     FLUX_RST       = 32'd65536;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAMBDA_MIN = 2'd0,
		CFG_LAMBDA_MAX = 2'd1,
		CFG_BINS       = 2'd2,
		CFG_FLUX       = 2'd3
	} cfg_reg_t;

	// item commands
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic prod_load;
		logic div_start;
		logic div_bin;
		logic lam_load;
		logic mul_load;
		logic bin_load;
		logic ram_rd;
		logic clr_wr;
		logic resp_zero;
		logic resp_read;
		logic resp_add;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;
		logic nu_zero;
		logic in_range;
		logic bin_ok;
		logic div_done;
		logic clr_last;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/wavelength_spectrum_binning_unit.sv @@
// top level of the wavelength spectrum binning unit
//
// An item is taken when start is high and busy is low. Every item gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it. An add with zero frequency
// skips the divisions; one whose wavelength falls outside the range does only the wavelength
// division, and one that reaches the bin range does both: the shared restoring divider does
// the wavelength division and then the bin division at one quotient bit per cycle over 56
// bits each. A new item may be started in the cycle that done is high. After reset the bin
// store is swept to zero with busy high. Configuration writes are taken at any edge with
// cfg_we high and must only be made while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none

module wavelength_spectrum_binning_unit import wsb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  command,
	input  wire logic [NU_W-1:0]       nu_khz,
	input  wire logic [ENERGY_W-1:0]   packet_energy,
	input  wire logic [IDX_W-1:0]      bin_select,
	output logic                       done,
	output logic                       binned,
	output logic      [IDX_W-1:0]      bin_index,
	output logic      [ACC_W-1:0]      bin_value
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer
	wsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// arithmetic and bin store
	wsb_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.nu_khz        (nu_khz),
		.packet_energy (packet_energy),
		.bin_select    (bin_select),
		.cmd           (cmd),
		.sts           (sts),
		.done          (done),
		.binned        (binned),
		.bin_index     (bin_index),
		.bin_value     (bin_value)
	);

endmodule

`default_nettype wire

@@ rtl/core/wsb_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module wsb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/wsb_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module wsb_divider import wsb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DIV_N_W-1:0] dividend,
	input  wire logic [DIV_D_W-1:0] divisor,
	output logic                    done,
	output logic      [DIV_N_W-1:0] quotient
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_D_W:0]     rem_sh;
	logic [DIV_D_W:0]     rem_sub;
	logic                 fits;

	// trial subtract of the shifted partial remainder
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_N_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		fits    = rem_sh >= {1'b0, den_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/wsb_datapath.sv @@
// datapath: registers, wavelength and bin arithmetic, bin store, result registers
`timescale 1ns / 1ps
`default_nettype none

module wsb_datapath import wsb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  command,
	input  wire logic [NU_W-1:0]       nu_khz,
	input  wire logic [ENERGY_W-1:0]   packet_energy,
	input  wire logic [IDX_W-1:0]      bin_select,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts,
	output logic                       done,
	output logic                       binned,
	output logic      [IDX_W-1:0]      bin_index,
	output logic      [ACC_W-1:0]      bin_value
);

	logic [LAM_W-1:0]      lam_min_q;
	logic [LAM_W-1:0]      lam_max_q;
	logic [BINS_CFG_W-1:0] bins_q;
	logic [FLUX_W-1:0]     flux_q;
	logic [NBINS_W-1:0]    nbins;

	logic                  cmd_q;
	logic [NU_W-1:0]       nu_q;
	logic [ENERGY_W-1:0]   energy_q;
	logic [IDX_W-1:0]      sel_q;
	logic [PROD_W-1:0]     prod_q;
	logic [DIV_N_W-1:0]    lambda_q;
	logic [LAM_W-1:0]      offs_q;
	logic [PROD2_W-1:0]    prod2_q;
	logic [LAM_W-1:0]      span_q;
	logic [BIN_W-1:0]      bin_q;
	logic [BIN_W-1:0]      clr_cnt_q;

	logic [DIV_N_W-1:0]    div_dividend;
	logic [DIV_D_W-1:0]    div_divisor;
	logic                  div_done;
	logic [DIV_N_W-1:0]    div_quo;

	logic                  ram_we;
	logic [BIN_W-1:0]      ram_waddr;
	logic [ACC_W-1:0]      ram_wdata;
	logic [BIN_W-1:0]      ram_raddr;
	logic [ACC_W-1:0]      ram_rdata;

	logic [ACC_W-1:0]      inc;
	logic [ACC_W:0]        sum_full;
	logic [ACC_W-1:0]      sum_sat;
	logic                  sel_ok;

	logic                  done_q;
	logic                  binned_q;
	logic [IDX_W-1:0]      index_q;
	logic [ACC_W-1:0]      value_q;

	// configuration registers, masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_min_q <= LAMBDA_MIN_RST;
			lam_max_q <= LAMBDA_MAX_RST;
			bins_q    <= BINS_RST;
			flux_q    <= FLUX_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_LAMBDA_MIN: lam_min_q <= cfg_data[LAM_W-1:0];
				CFG_LAMBDA_MAX: lam_max_q <= cfg_data[LAM_W-1:0];
				CFG_BINS:       bins_q    <= cfg_data[BINS_CFG_W-1:0];
				CFG_FLUX:       flux_q    <= cfg_data[FLUX_W-1:0];
				default: ;
			endcase
		end
	end

	// effective bin count, clipped to the store depth
	assign nbins = (32'(bins_q) > MAX_BINS) ? NBINS_W'(MAX_BINS) : NBINS_W'(bins_q);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			nu_q     <= nu_khz;
			energy_q <= packet_energy;
			sel_q    <= bin_select;
		end
	end

	// flux increment product, Q16.16 times Q16.16
	always_ff @(posedge clk) begin
		if (cmd.prod_load) begin
			prod_q <= energy_q * flux_q;
		end
	end
	assign inc = prod_q[PROD_W-1:16];

	// wavelength and its offset from the lower edge
	always_ff @(posedge clk) begin
		if (cmd.lam_load) begin
			lambda_q <= div_quo;
			offs_q   <= div_quo[LAM_W-1:0] - lam_min_q;
		end
	end

	// scaled offset and span for the bin division
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			prod2_q <= PROD2_W'(offs_q) * PROD2_W'(nbins);
			span_q  <= lam_max_q - lam_min_q;
		end
	end

	// bin number
	always_ff @(posedge clk) begin
		if (cmd.bin_load) begin
			bin_q <= BIN_W'(div_quo);
		end
	end

	// shared divider operand select
	always_comb begin
		if (cmd.div_bin) begin
			div_dividend = DIV_N_W'(prod2_q);
			div_divisor  = DIV_D_W'(span_q);
		end else begin
			div_dividend = WAVE_NUM;
			div_divisor  = nu_q;
		end
	end

	wsb_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// saturating accumulate
	always_comb begin
		sum_full = {1'b0, ram_rdata} + {1'b0, inc};
		sum_sat  = sum_full[ACC_W] ? {ACC_W{1'b1}} : sum_full[ACC_W-1:0];
		sel_ok   = 32'(sel_q) < 32'(nbins);
	end

	// bin store ports
	always_comb begin
		ram_we    = cmd.clr_wr | cmd.resp_add;
		ram_waddr = cmd.clr_wr ? clr_cnt_q : bin_q;
		ram_wdata = cmd.clr_wr ? '0 : sum_sat;
		ram_raddr = (cmd_q == CMD_READ) ? BIN_W'(sel_q) : bin_q;
	end

	wsb_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.ram_rd),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.resp_zero | cmd.resp_read | cmd.resp_add;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.resp_zero) begin
			binned_q <= 1'b0;
			index_q  <= '0;
			value_q  <= '0;
		end else if (cmd.resp_read) begin
			binned_q <= 1'b0;
			index_q  <= sel_q;
			value_q  <= sel_ok ? ram_rdata : '0;
		end else if (cmd.resp_add) begin
			binned_q <= 1'b1;
			index_q  <= IDX_W'(bin_q);
			value_q  <= sum_sat;
		end
	end

	// status to the controller
	always_comb begin
		sts.is_read  = (cmd_q == CMD_READ);
		sts.nu_zero  = (nu_q == '0);
		sts.in_range = (lambda_q >= DIV_N_W'(lam_min_q)) && (lambda_q < DIV_N_W'(lam_max_q));
		sts.bin_ok   = div_quo < DIV_N_W'(nbins);
		sts.div_done = div_done;
		sts.clr_last = (clr_cnt_q == BIN_W'(MAX_BINS - 1));
	end

	assign done      = done_q;
	assign binned    = binned_q;
	assign bin_index = index_q;
	assign bin_value = value_q;

endmodule

`default_nettype wire

@@ rtl/core/wsb_ctrl.sv @@
// controller: sequences clearing, the two divisions and the bin update
`timescale 1ns / 1ps
`default_nettype none

module wsb_ctrl import wsb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd,
	output logic         busy
);

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b0000000001,
		S_IDLE     = 10'b0000000010,
		S_DECODE   = 10'b0000000100,
		S_DIV_WAVE = 10'b0000001000,
		S_CHECK    = 10'b0000010000,
		S_MUL      = 10'b0000100000,
		S_DIV_BIN  = 10'b0001000000,
		S_READ     = 10'b0010000000,
		S_UPDATE   = 10'b0100000000,
		S_ZERO     = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// state register, reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_read) begin
					state_d = S_READ;
				end else if (sts.nu_zero) begin
					state_d = S_ZERO;
				end else begin
					cmd.div_start = 1'b1;
					cmd.prod_load = 1'b1;
					state_d       = S_DIV_WAVE;
				end
			end
			S_DIV_WAVE: begin
				if (sts.div_done) begin
					cmd.lam_load = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.in_range) begin
					cmd.mul_load = 1'b1;
					state_d      = S_MUL;
				end else begin
					state_d = S_ZERO;
				end
			end
			S_MUL: begin
				cmd.div_start = 1'b1;
				cmd.div_bin   = 1'b1;
				state_d       = S_DIV_BIN;
			end
			S_DIV_BIN: begin
				cmd.div_bin = 1'b1;
				if (sts.div_done) begin
					if (sts.bin_ok) begin
						cmd.bin_load = 1'b1;
						state_d      = S_READ;
					end else begin
						state_d = S_ZERO;
					end
				end
			end
			S_READ: begin
				cmd.ram_rd = 1'b1;
				state_d    = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.resp_read = sts.is_read;
				cmd.resp_add  = !sts.is_read;
				state_d       = S_IDLE;
			end
			S_ZERO: begin
				cmd.resp_zero = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/wsb_checker.sv @@
// port-level checker of the spectrum binning unit and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "wavelength_spectrum_binning_unit_defines.svh"

module wsb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// an accepted item keeps the unit busy in the next cycle
	`WSB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// a result is a single-cycle pulse
	`WSB_ASSERT_NEXT(a_done_pulse, done, !done)

	// a result shows only once the unit is idle again
	`WSB_ASSERT_NOW(a_done_idle, done, !busy)

	// a result always follows a cycle of work
	`WSB_ASSERT_NOW(a_done_after_work, done, $past(busy))

endmodule

bind wavelength_spectrum_binning_unit wsb_checker u_wsb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

@@ tb/wavelength_spectrum_binning_unit_tb.sv @@
// testbench for the wavelength spectrum binning unit: directed and random items against a bin model
`timescale 1ns / 1ps

module wavelength_spectrum_binning_unit_tb;
	import wsb_pkg::*;

	// one result of the unit
	typedef struct packed {
		logic             binned;
		logic [IDX_W-1:0] idx;
		logic [ACC_W-1:0] value;
	} bin_result_t;

	// model of the bin store and queue of results still owed by the unit
	class bin_tally;
		logic [LAM_W-1:0]      lam_lo;
		logic [LAM_W-1:0]      lam_hi;
		logic [BINS_CFG_W-1:0] bin_count;
		logic [FLUX_W-1:0]     flux_gain;
		logic [ACC_W-1:0]      flux_acc [MAX_BINS];
		bin_result_t           pending [$];
		int                    fails;

		function new();
			lam_lo    = LAMBDA_MIN_RST;
			lam_hi    = LAMBDA_MAX_RST;
			bin_count = BINS_RST;
			flux_gain = FLUX_RST;
			foreach (flux_acc[i])
				flux_acc[i] = '0;
			fails = 0;
		endfunction

		function void set_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] data);
			case (which)
				CFG_LAMBDA_MIN: lam_lo = data[LAM_W-1:0];
				CFG_LAMBDA_MAX: lam_hi = data[LAM_W-1:0];
				CFG_BINS:       bin_count = data[BINS_CFG_W-1:0];
				CFG_FLUX:       flux_gain = data[FLUX_W-1:0];
				default: ;
			endcase
		endfunction

		// bin one accepted item and queue the result it owes
		function void take_item(logic cmd, logic [NU_W-1:0] nu, logic [ENERGY_W-1:0] energy,
				logic [IDX_W-1:0] sel);
			bin_result_t r;
			logic [63:0] nb, lam, span, slot, inc, sum;
			r = '0;
			nb = (bin_count > MAX_BINS) ? 64'(MAX_BINS) : 64'(bin_count);
			if (cmd == CMD_READ) begin
				r.idx = sel;
				if (64'(sel) < nb)
					r.value = flux_acc[sel];
			end else if (nu != '0) begin
				lam = 64'(WAVE_NUM) / 64'(nu);
				if (lam >= 64'(lam_lo) && lam < 64'(lam_hi)) begin
					span = 64'(lam_hi) - 64'(lam_lo);
					slot = ((lam - 64'(lam_lo)) * nb) / span;
					if (slot < nb) begin
						inc = (64'(energy) * 64'(flux_gain)) >> 16;
						sum = 64'(flux_acc[slot]) + inc;
						// accumulator saturates at full scale
						if (sum > 64'({ACC_W{1'b1}}))
							sum = 64'({ACC_W{1'b1}});
						flux_acc[slot] = sum[ACC_W-1:0];
						r.binned = 1'b1;
						r.idx    = slot[IDX_W-1:0];
						r.value  = sum[ACC_W-1:0];
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic got_binned, logic [IDX_W-1:0] got_idx,
				logic [ACC_W-1:0] got_value);
			bin_result_t want;
			if (pending.size() == 0) begin
				fails++;
				$display("%0t: result with none pending: binned %0d index %0d value %h",
					$time, got_binned, got_idx, got_value);
				return;
			end
			want = pending.pop_front();
			if (got_binned !== want.binned) begin
				fails++;
				$display("%0t: binned expected %0d actual %0d", $time, want.binned, got_binned);
			end
			if (got_idx !== want.idx) begin
				fails++;
				$display("%0t: bin_index expected %0d actual %0d", $time, want.idx, got_idx);
			end
			if (got_value !== want.value) begin
				fails++;
				$display("%0t: bin_value expected %h actual %h", $time, want.value, got_value);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	logic                  busy;
	logic                  command;
	logic [NU_W-1:0]       nu_khz;
	logic [ENERGY_W-1:0]   packet_energy;
	logic [IDX_W-1:0]      bin_select;
	logic                  done;
	logic                  binned;
	logic [IDX_W-1:0]      bin_index;
	logic [ACC_W-1:0]      bin_value;

	bin_tally tally = new();
	int unsigned send_idle;

	// random settings: wavelength edges, bin count, flux factor
	int unsigned set_lo [8] = '{8000, 0, 16000, 1000, 300000, 500000, 171, 4000};
	int unsigned set_hi [8] = '{320000, 268435455, 16100, 2000000, 300000, 400000, 200000,
		6000000};
	int unsigned set_bins [8] = '{1024, 2047, 7, 1, 512, 100, 0, 1000};
	int unsigned set_gain [8] = '{65536, 0, 32'hFFFF_0000, 32'h0001_8000, 65536,
		32'h0001_2345, 32'h0000_8000, 32'hFFFF_FFFF};

	wavelength_spectrum_binning_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.nu_khz        (nu_khz),
		.packet_energy (packet_energy),
		.bin_select    (bin_select),
		.done          (done),
		.binned        (binned),
		.bin_index     (bin_index),
		.bin_value     (bin_value)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			tally.check_result(binned, bin_index, bin_value);
	end

	// smallest frequency whose wavelength is at most lam
	function automatic logic [NU_W-1:0] nu_for_lambda(input logic [63:0] lam);
		logic [63:0] q;
		q = 64'(WAVE_NUM) / (lam + 64'd1) + 64'd1;
		return q[NU_W-1:0];
	endfunction

	// offer one item, idling at random, until the unit takes it
	task automatic send_item(input logic cmd, input logic [NU_W-1:0] nu,
			input logic [ENERGY_W-1:0] energy, input logic [IDX_W-1:0] sel);
		logic offer;
		command       <= cmd;
		nu_khz        <= nu;
		packet_energy <= energy;
		bin_select    <= sel;
		forever begin
			offer = ($urandom_range(99) >= send_idle);
			start <= offer;
			@(posedge clk);
			if (offer && !busy)
				break;
		end
		tally.take_item(cmd, nu, energy, sel);
	endtask

	// mostly in-range packets with random content, plus reads and noise
	task automatic send_random_item();
		int unsigned pick, a, b;
		logic [63:0] raw;
		logic [NU_W-1:0] nu;
		logic [ENERGY_W-1:0] energy;
		pick = $urandom_range(99);
		raw = {$urandom, $urandom};
		energy = $urandom_range(1) ? $urandom : $urandom_range(4095);
		a = (tally.lam_lo < tally.lam_hi) ? tally.lam_lo : tally.lam_hi;
		b = (tally.lam_lo < tally.lam_hi) ? tally.lam_hi : tally.lam_lo;
		if (a < 171)
			a = 171;
		if (b <= a)
			b = a + 1;
		if (pick < 20) begin
			send_item(CMD_READ, raw[NU_W-1:0], energy, IDX_W'($urandom));
		end else if (pick < 85) begin
			nu = nu_for_lambda($urandom_range(b - 1, a));
			send_item(CMD_ADD, nu, energy, IDX_W'($urandom));
		end else begin
			case ($urandom_range(3))
				0: nu = '0;
				1: nu = raw[NU_W-1:0];
				2: nu = raw[NU_W-1:0] >> $urandom_range(NU_W - 1);
				default: nu = nu_for_lambda($urandom_range(1) ? b : a - 1);
			endcase
			send_item(CMD_ADD, nu, energy, IDX_W'($urandom));
		end
	endtask

	// wait until every owed result is in and the unit is quiet
	task automatic settle();
		start <= 1'b0;
		while (tally.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= data;
		@(posedge clk);
		tally.set_reg(which, data);
	endtask

	// write all four registers, with junk above the width of each register narrower than the data
	task automatic write_setting(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] count, input logic [31:0] gain);
		write_reg(CFG_LAMBDA_MIN, {4'($urandom), lo[LAM_W-1:0]});
		write_reg(CFG_LAMBDA_MAX, {4'($urandom), hi[LAM_W-1:0]});
		write_reg(CFG_BINS, {21'($urandom), count[BINS_CFG_W-1:0]});
		write_reg(CFG_FLUX, gain);
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_LAMBDA_MIN;
		cfg_data      <= '0;
		start         <= 1'b0;
		command       <= CMD_ADD;
		nu_khz        <= '0;
		packet_energy <= '0;
		bin_select    <= '0;
		send_idle = 30;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: cleared bins, zero frequency, range edges
		send_item(CMD_READ, '0, '0, '0);
		send_item(CMD_READ, '1, '1, '1);
		send_item(CMD_ADD, '0, 32'hFFFF_FFFF, '0);
		send_item(CMD_ADD, '1, 32'hFFFF_FFFF, '1);
		send_item(CMD_ADD, 48'd1, 32'hFFFF_FFFF, '0);
		send_item(CMD_ADD, nu_for_lambda(8000), 32'hFFFF_FFFF, '0);
		send_item(CMD_ADD, nu_for_lambda(7999), 32'd5, '0);
		send_item(CMD_ADD, nu_for_lambda(319999), 32'd1, '0);
		send_item(CMD_ADD, nu_for_lambda(320000), 32'd7, '0);
		send_item(CMD_ADD, nu_for_lambda(150000), '0, '0);
		send_item(CMD_READ, '0, '0, 10'd0);
		send_item(CMD_READ, '0, '0, 10'd1023);
		settle();

		// full-scale flux: accumulator saturation, reads past the bin count
		write_setting(8000, 320000, 2, 32'hFFFF_FFFF);
		repeat (3)
			send_item(CMD_ADD, nu_for_lambda(8000), 32'hFFFF_FFFF, '0);
		send_item(CMD_ADD, nu_for_lambda(319999), 32'h0001_0000, '0);
		send_item(CMD_READ, '0, '0, 10'd0);
		send_item(CMD_READ, '0, '0, 10'd1);
		send_item(CMD_READ, '0, '0, 10'd2);
		send_item(CMD_READ, '0, '0, 10'd1023);
		settle();

		// zero bins in use: nothing lands, reads return zero
		write_setting(8000, 320000, 0, 32'h0001_0000);
		send_item(CMD_ADD, nu_for_lambda(9000), 32'h0000_1000, '0);
		send_item(CMD_READ, '0, '0, 10'd0);
		settle();

		// random phases over several settings
		for (int s = 0; s < 8; s++) begin
			send_idle = (s < 3) ? 30 : (s < 6) ? 55 : 0;
			write_setting(set_lo[s], set_hi[s], set_bins[s], set_gain[s]);
			repeat (180)
				send_random_item();
			settle();
		end

		repeat (130) @(posedge clk);
		if (tally.fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#12_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ wavelength_spectrum_binning_unit.f @@
+incdir+rtl/core
rtl/core/wsb_pkg.sv
rtl/core/wsb_ram.sv
rtl/core/wsb_divider.sv
rtl/core/wsb_datapath.sv
rtl/core/wsb_ctrl.sv
rtl/core/wavelength_spectrum_binning_unit.sv
rtl/core/wsb_checker.sv
tb/wavelength_spectrum_binning_unit_tb.sv
